>>> hw/rtl/rtc_pkg.sv
package rtc_pkg;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [3:0] ADDR_CONTROL     = 4'd1;
   localparam logic [3:0] ADDR_SECONDS     = 4'd4;
   localparam logic [3:0] ADDR_MINUTES     = 4'd5;
   localparam logic [3:0] ADDR_HOURS       = 4'd6;
   localparam logic [3:0] ADDR_DAYS        = 4'd7;
   localparam logic [3:0] ADDR_WEEKDAY     = 4'd8;
   localparam logic [3:0] ADDR_MONTH       = 4'd9;
   localparam logic [3:0] ADDR_YEAR        = 4'd10;
   localparam logic [3:0] ADDR_ALARM_FIRST = 4'd11;
   localparam logic [3:0] ADDR_ALARM_LAST  = 4'd15;

   localparam int ALARM_COUNT = 5;

   localparam int CTL_AIE_BIT = 7;
   localparam int CTL_AF_BIT  = 6;
   localparam logic [7:0] CTL_FLAGS = 8'h48;   // AF and TF
   localparam int ALARM_OFF_BIT = 7;

   localparam logic [7:0] SEC_LAST  = 8'h59;
   localparam logic [7:0] MIN_LAST  = 8'h59;
   localparam logic [7:0] HOUR_LAST = 8'h23;
   localparam logic [7:0] MON_LAST  = 8'h12;
   localparam logic [7:0] YEAR_LAST = 8'h99;
   localparam logic [7:0] BCD_ZERO  = 8'h00;
   localparam logic [7:0] BCD_ONE   = 8'h01;
   localparam logic [2:0] WDAY_LAST = 3'd6;
   localparam logic [2:0] WDAY_RESET = 3'd6;

   // Year codes that decode to 2100, the only non-leap multiple of four in range:
   // the tens digit ten with units zero, and the tens digit nine with units ten.
   localparam logic [7:0] YEAR_CENTURY     = 8'hA0;
   localparam logic [7:0] YEAR_CENTURY_ALT = 8'h9A;

   localparam logic [7:0] ALARM_MASK [ALARM_COUNT] = '{8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h07};

   typedef struct packed {
      logic [6:0] sec;
      logic [6:0] min;
      logic [5:0] hour;
      logic [5:0] day;
      logic [2:0] wday;
      logic [4:0] mon;
      logic [7:0] year;
   } time_type;

   typedef struct packed {
      logic       alarm_irq;
      logic [7:0] read_data;
   } rsp_type;

   // One BCD count step: bit 8 is the carry out, bits 7..0 the new value.
   function automatic logic [8:0] bcd_step(input logic [7:0] x, input logic [7:0] last,
                                           input logic [7:0] first);
      logic [8:0] r;
      if (x >= last) begin
         r = {1'b1, first};
      end else if (x[3:0] >= 4'd9) begin
         r = {1'b0, x[7:4] + 4'd1, 4'd0};
      end else begin
         r = {1'b0, x + 8'd1};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/rtc_tick_logic.sv
module rtc_tick_logic (
   input  rtc_pkg::time_type             cur,
   input  logic [rtc_pkg::ALARM_COUNT-1:0][7:0] alarm,
   output rtc_pkg::time_type             nxt,
   output logic                          alarm_hit
);
   import rtc_pkg::*;

   logic [8:0] sec_r, min_r, hour_r, day_r, mon_r, year_r;
   logic [7:0] last_day;
   logic [1:0] mod4;
   logic       leap;
   logic [7:0] field [ALARM_COUNT];
   logic       any_on, all_match;

   // The year is 2000 plus the BCD value; 2000 is a multiple of 400 and four.
   assign mod4 = {cur.year[4], 1'b0} + cur.year[1:0];
   assign leap = (mod4 == 2'd0) && (cur.year != YEAR_CENTURY) &&
                 (cur.year != YEAR_CENTURY_ALT);

   always_comb begin
      case (cur.mon)
         5'h04, 5'h06, 5'h09, 5'h11: last_day = 8'h30;
         5'h02:                      last_day = leap ? 8'h29 : 8'h28;
         default:                    last_day = 8'h31;
      endcase
   end

   always_comb begin
      sec_r  = bcd_step({1'b0, cur.sec}, SEC_LAST, BCD_ZERO);
      min_r  = bcd_step({1'b0, cur.min}, MIN_LAST, BCD_ZERO);
      hour_r = bcd_step({2'b00, cur.hour}, HOUR_LAST, BCD_ZERO);
      day_r  = bcd_step({2'b00, cur.day}, last_day, BCD_ONE);
      mon_r  = bcd_step({3'b000, cur.mon}, MON_LAST, BCD_ONE);
      year_r = bcd_step(cur.year, YEAR_LAST, BCD_ZERO);

      nxt = cur;
      nxt.sec = sec_r[6:0];
      if (sec_r[8]) begin
         nxt.min = min_r[6:0];
         if (min_r[8]) begin
            nxt.hour = hour_r[5:0];
            if (hour_r[8]) begin
               nxt.wday = (cur.wday >= WDAY_LAST) ? 3'd0 : cur.wday + 3'd1;
               nxt.day = day_r[5:0];
               if (day_r[8]) begin
                  nxt.mon = mon_r[4:0];
                  if (mon_r[8]) begin
                     nxt.year = year_r[7:0];
                  end
               end
            end
         end
      end
   end

   // Alarm fields are compared against the time after the advance.
   always_comb begin
      field[0] = {1'b0, nxt.sec};
      field[1] = {1'b0, nxt.min};
      field[2] = {2'b00, nxt.hour};
      field[3] = {2'b00, nxt.day};
      field[4] = {5'b00000, nxt.wday};
      any_on = 1'b0;
      all_match = 1'b1;
      for (int k = 0; k < ALARM_COUNT; k++) begin
         if (!alarm[k][ALARM_OFF_BIT]) begin
            any_on = 1'b1;
            if ((alarm[k] & ALARM_MASK[k]) != field[k]) begin
               all_match = 1'b0;
            end
         end
      end
      alarm_hit = any_on && all_match;
   end

endmodule

>>> hw/rtl/rtc_regfile.sv
module rtc_regfile (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rtc_pkg::action_type action,
   input  logic [3:0]       reg_addr,
   input  logic [7:0]       write_data,
   output rtc_pkg::rsp_type result
);
   import rtc_pkg::*;

   logic [7:0] ctl_ff, ctl_in;
   logic       os_ff, os_in;
   time_type   time_ff, time_in, time_tick;
   logic [ALARM_COUNT-1:0][7:0] alarm_ff, alarm_in;
   logic       alarm_hit;
   logic [2:0] alarm_idx;
   logic [7:0] rd;

   rtc_tick_logic u_tick (
      .cur       (time_ff),
      .alarm     (alarm_ff),
      .nxt       (time_tick),
      .alarm_hit (alarm_hit)
   );

   assign alarm_idx = 3'(reg_addr - ADDR_ALARM_FIRST);

   always_comb begin
      case (reg_addr)
         ADDR_CONTROL: rd = ctl_ff;
         ADDR_SECONDS: rd = {os_ff, time_ff.sec};
         ADDR_MINUTES: rd = {1'b0, time_ff.min};
         ADDR_HOURS:   rd = {2'b00, time_ff.hour};
         ADDR_DAYS:    rd = {2'b00, time_ff.day};
         ADDR_WEEKDAY: rd = {5'b00000, time_ff.wday};
         ADDR_MONTH:   rd = {3'b000, time_ff.mon};
         ADDR_YEAR:    rd = time_ff.year;
         default: begin
            if (reg_addr inside {[ADDR_ALARM_FIRST:ADDR_ALARM_LAST]}) begin
               rd = alarm_ff[alarm_idx];
            end else begin
               rd = 8'h00;
            end
         end
      endcase
   end

   always_comb begin
      ctl_in = ctl_ff;
      os_in = os_ff;
      time_in = time_ff;
      alarm_in = alarm_ff;
      case (action)
         ACT_WRITE: begin
            case (reg_addr)
               ADDR_CONTROL: ctl_in = (write_data & ~CTL_FLAGS) |
                                      (ctl_ff & write_data & CTL_FLAGS);
               ADDR_SECONDS: begin
                  time_in.sec = write_data[6:0];
                  os_in = 1'b0;
               end
               ADDR_MINUTES: time_in.min  = write_data[6:0];
               ADDR_HOURS:   time_in.hour = write_data[5:0];
               ADDR_DAYS:    time_in.day  = write_data[5:0];
               ADDR_WEEKDAY: time_in.wday = write_data[2:0];
               ADDR_MONTH:   time_in.mon  = write_data[4:0];
               ADDR_YEAR:    time_in.year = write_data;
               default: begin
                  if (reg_addr inside {[ADDR_ALARM_FIRST:ADDR_ALARM_LAST]}) begin
                     alarm_in[alarm_idx] = write_data;
                  end
               end
            endcase
         end
         ACT_TICK: begin
            time_in = time_tick;
            if (alarm_hit) begin
               ctl_in[CTL_AF_BIT] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign result.read_data = (action == ACT_READ) ? rd : 8'h00;
   assign result.alarm_irq = ctl_in[CTL_AF_BIT] && ctl_in[CTL_AIE_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= 8'h00;
         os_ff <= 1'b1;
         time_ff <= '{sec: 7'h00, min: 7'h00, hour: 6'h00, day: 6'h01,
                      wday: WDAY_RESET, mon: 5'h01, year: 8'h00};
         alarm_ff <= {ALARM_COUNT{8'h80}};
      end else if (accept) begin
         ctl_ff <= ctl_in;
         os_ff <= os_in;
         time_ff <= time_in;
         alarm_ff <= alarm_in;
      end
   end

endmodule

>>> hw/rtl/rtc_out_skid.sv
module rtc_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rtc_pkg::rsp_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output rtc_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import rtc_pkg::*;

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    take, push;

   assign take = main_valid_ff && out_ready;
   assign push = in_valid && in_ready;
   assign in_ready = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            main_ff <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_ff <= in_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

>>> hw/rtl/rtc_calendar_alarm_registers.sv
// Channel   Direction  Ports                        Contents
// req       in         req_tvalid/tready/tdata/user  register access or one-second tick
// rsp       out        rsp_tvalid/tready/tdata       read byte and alarm interrupt level
//
// Every request is handled in the cycle it is accepted, so one request per cycle is taken
// while the buffer has room. The register file and calendar update at the accepting edge;
// the response goes to a two-entry output buffer; requests keep flowing while one waits.
// A synchronous active-high reset loads the power-on calendar and disables all alarms.
// Ready drops only when both output entries are full, until the consumer takes one.
module rtc_calendar_alarm_registers (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] reg_addr, [11:4] write_data, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [8] alarm_irq, [15:9] zero
);
   import rtc_pkg::*;

   logic       accept;
   action_type action;
   rsp_type    result, rsp_data;

   // A request is taken when the output buffer has room.
   assign accept = req_tvalid && req_tready;
   assign action = action_type'(req_tuser);

   // The register file holds the calendar state and works out each response
   // combinationally from the request and the current state.
   rtc_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (action),
      .reg_addr   (req_tdata[3:0]),
      .write_data (req_tdata[11:4]),
      .result     (result)
   );

   // The output buffer decouples the response side from the request side.
   rtc_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_data   (result),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {7'b0000000, rsp_data.alarm_irq, rsp_data.read_data};

endmodule

>>> hw/rtl/rtc_checker.sv
module rtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import rtc_pkg::*;

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An accepted request always leaves a response waiting.
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // Writes, ticks and the unused action code return a zero read byte.
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && (req_tuser != ACT_READ)
      |=> rsp_tdata[7:0] == 8'h00)
      else $error("non-read request returned read data");

endmodule

bind rtc_calendar_alarm_registers rtc_checker u_rtc_checker (.*);

>>> tb/rtc_calendar_alarm_registers_checker.sv
`timescale 1ns / 1ps

module rtc_calendar_alarm_registers_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] reg_addr, [11:4] write_data, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] read_data, [8] alarm_irq, [15:9] zero
   output int          error_count,
   output int          pending_count,
   output int          response_count,
   output int          irq_count
);
   import rtc_pkg::*;

   localparam int CENTURY_BASE = 2000;

   // Shadow copy of the clock registers.
   logic [7:0] ctl_q;
   logic       os_q;
   logic [6:0] sec_q;
   logic [6:0] min_q;
   logic [5:0] hour_q;
   logic [5:0] day_q;
   logic [2:0] wday_q;
   logic [4:0] mon_q;
   logic [7:0] year_q;
   logic [7:0] alarm_q [ALARM_COUNT];

   rsp_type expected_rsp_q [$];

   // Returns 1 on wrap, in which case the field restarts at its first value.
   function automatic bit bcd_advance(input logic [7:0] cur, input logic [7:0] last,
                                      input logic [7:0] first, output logic [7:0] nxt);
      if (cur >= last) begin
         nxt = first;
         return 1'b1;
      end
      if (cur[3:0] >= 4'd9) begin
         nxt = {cur[7:4] + 4'd1, 4'd0};
      end else begin
         nxt = cur + 8'd1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] last_day_of_month(input logic [4:0] mon,
                                                    input logic [7:0] yr);
      int full_year;
      full_year = CENTURY_BASE + int'(yr[7:4]) * 10 + int'(yr[3:0]);
      case (mon)
         5'h04, 5'h06, 5'h09, 5'h11: return 8'h30;
         5'h02: begin
            if ((full_year % 4 == 0 && full_year % 100 != 0) || full_year % 400 == 0) begin
               return 8'h29;
            end
            return 8'h28;
         end
         default: return 8'h31;
      endcase
   endfunction

   function automatic logic [7:0] alarmed_field(input int k);
      case (k)
         0: return {1'b0, sec_q};
         1: return {1'b0, min_q};
         2: return {2'b0, hour_q};
         3: return {2'b0, day_q};
         default: return {5'b0, wday_q};
      endcase
   endfunction

   task automatic load_power_on_state();
      ctl_q  = 8'h00;
      os_q   = 1'b1;
      sec_q  = '0;
      min_q  = '0;
      hour_q = '0;
      day_q  = 6'(BCD_ONE);
      wday_q = WDAY_RESET;
      mon_q  = 5'(BCD_ONE);
      year_q = BCD_ZERO;
      for (int k = 0; k < ALARM_COUNT; k++) begin
         alarm_q[k] = 8'h80;
      end
   endtask

   task automatic advance_one_second();
      logic [7:0] nxt;
      bit         wrapped;
      bit         any_enabled;
      bit         all_match;
      wrapped = bcd_advance({1'b0, sec_q}, SEC_LAST, BCD_ZERO, nxt);
      sec_q = nxt[6:0];
      if (wrapped) begin
         wrapped = bcd_advance({1'b0, min_q}, MIN_LAST, BCD_ZERO, nxt);
         min_q = nxt[6:0];
         if (wrapped) begin
            wrapped = bcd_advance({2'b0, hour_q}, HOUR_LAST, BCD_ZERO, nxt);
            hour_q = nxt[5:0];
            if (wrapped) begin
               // A new day: weekday 6 and the unused code 7 both wrap to 0.
               wday_q = (wday_q >= WDAY_LAST) ? 3'd0 : wday_q + 3'd1;
               wrapped = bcd_advance({2'b0, day_q}, last_day_of_month(mon_q, year_q),
                                     BCD_ONE, nxt);
               day_q = nxt[5:0];
               if (wrapped) begin
                  wrapped = bcd_advance({3'b0, mon_q}, MON_LAST, BCD_ONE, nxt);
                  mon_q = nxt[4:0];
                  if (wrapped) begin
                     wrapped = bcd_advance(year_q, YEAR_LAST, BCD_ZERO, nxt);
                     year_q = nxt;
                  end
               end
            end
         end
      end
      any_enabled = 1'b0;
      all_match   = 1'b1;
      for (int k = 0; k < ALARM_COUNT; k++) begin
         if (!alarm_q[k][ALARM_OFF_BIT]) begin
            any_enabled = 1'b1;
            if ((alarm_q[k] & ALARM_MASK[k]) != alarmed_field(k)) begin
               all_match = 1'b0;
            end
         end
      end
      if (any_enabled && all_match) begin
         ctl_q[CTL_AF_BIT] = 1'b1;
      end
   endtask

   function automatic logic [7:0] register_byte(input logic [3:0] addr);
      case (addr)
         ADDR_CONTROL: return ctl_q;
         ADDR_SECONDS: return {os_q, sec_q};
         ADDR_MINUTES: return {1'b0, min_q};
         ADDR_HOURS:   return {2'b0, hour_q};
         ADDR_DAYS:    return {2'b0, day_q};
         ADDR_WEEKDAY: return {5'b0, wday_q};
         ADDR_MONTH:   return {3'b0, mon_q};
         ADDR_YEAR:    return year_q;
         default: begin
            if (addr >= ADDR_ALARM_FIRST && addr <= ADDR_ALARM_LAST) begin
               return alarm_q[3'(addr - ADDR_ALARM_FIRST)];
            end
            return 8'h00;
         end
      endcase
   endfunction

   task automatic store_register(input logic [3:0] addr, input logic [7:0] data);
      case (addr)
         // The flag bits can only be cleared by software, never set.
         ADDR_CONTROL: ctl_q = (data & ~CTL_FLAGS) | (ctl_q & data & CTL_FLAGS);
         ADDR_SECONDS: begin
            sec_q = data[6:0];
            os_q  = 1'b0;
         end
         ADDR_MINUTES: min_q  = data[6:0];
         ADDR_HOURS:   hour_q = data[5:0];
         ADDR_DAYS:    day_q  = data[5:0];
         ADDR_WEEKDAY: wday_q = data[2:0];
         ADDR_MONTH:   mon_q  = data[4:0];
         ADDR_YEAR:    year_q = data;
         default: begin
            if (addr >= ADDR_ALARM_FIRST && addr <= ADDR_ALARM_LAST) begin
               alarm_q[3'(addr - ADDR_ALARM_FIRST)] = data;
            end
         end
      endcase
   endtask

   task automatic apply_request(input action_type act, input logic [3:0] addr,
                                input logic [7:0] data, output rsp_type rsp);
      rsp.read_data = 8'h00;
      case (act)
         ACT_READ:  rsp.read_data = register_byte(addr);
         ACT_WRITE: store_register(addr, data);
         ACT_TICK:  advance_one_second();
         default: ;
      endcase
      rsp.alarm_irq = ctl_q[CTL_AF_BIT] & ctl_q[CTL_AIE_BIT];
   endtask

   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         load_power_on_state();
         expected_rsp_q.delete();
         error_count    = 0;
         response_count = 0;
         irq_count      = 0;
      end else begin
         // Responses leave a registered buffer, so the oldest entry is never the one
         // pushed at this same edge unless the queue was empty.
         if (req_tvalid && req_tready) begin
            apply_request(action_type'(req_tuser), req_tdata[3:0], req_tdata[11:4],
                          predicted);
            expected_rsp_q.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            if (expected_rsp_q.size() == 0) begin
               $error("response with nothing outstanding, rsp_tdata %h", rsp_tdata);
               error_count++;
            end else begin
               oldest = expected_rsp_q.pop_front();
               if (oldest.alarm_irq) begin
                  irq_count++;
               end
               if (rsp_tdata[7:0] !== oldest.read_data) begin
                  $error("read_data: expected %h, actual %h", oldest.read_data,
                         rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[8] !== oldest.alarm_irq) begin
                  $error("alarm_irq: expected %b, actual %b", oldest.alarm_irq,
                         rsp_tdata[8]);
                  error_count++;
               end
               if (rsp_tdata[15:9] !== 7'd0) begin
                  $error("padding: expected %h, actual %h", 7'd0, rsp_tdata[15:9]);
                  error_count++;
               end
            end
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

>>> tb/rtc_calendar_alarm_registers_tb.sv
`timescale 1ns / 1ps

// The top level only generates traffic and decides the verdict. All prediction and
// comparison lives in the checker instantiated next to the clock block.
module rtc_calendar_alarm_registers_tb;
   import rtc_pkg::*;

   // Sizes of the run. The quiet tail disables all random idling on both sides.
   localparam int RANDOM_ITEMS   = 1900;
   localparam int DIRECTED_ITEMS = 25;
   localparam int QUIET_FROM     = DIRECTED_ITEMS + RANDOM_ITEMS - 150;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_LIMIT    = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [3:0] reg_addr, [11:4] write_data, [15:12] zero
   logic [1:0]  req_tuser;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] read_data, [8] alarm_irq, [15:9] zero

   int error_count;
   int pending_count;
   int response_count;
   int irq_count;

   // Shared between the stimulus, the receiver and the watchdog processes.
   bit quiet;
   bit long_hold_pending;
   int issued_count;
   int tick_count;
   int idle_cycles;

   rtc_calendar_alarm_registers dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rtc_calendar_alarm_registers_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .response_count (response_count),
      .irq_count      (irq_count)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // Converts a small decimal number into two BCD digits.
   function automatic logic [7:0] to_bcd(input int value);
      logic [7:0] digits;
      digits[7:4] = 4'(value / 10);
      digits[3:0] = 4'(value % 10);
      return digits;
   endfunction

   // Offers one request and returns at the edge where it is accepted. A random gap
   // may come first; valid is lowered at one edge and raised at a later one, so the
   // two assignments never fall in the same time step.
   task automatic issue_request(input action_type act, input logic [3:0] addr,
                                input logic [7:0] data);
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, data, addr};
      do begin
         @(posedge clock);
      end while (!req_tready);
      issued_count++;
      if (act == ACT_TICK) begin
         tick_count++;
      end
      if (issued_count >= QUIET_FROM) begin
         quiet = 1'b1;
      end
   endtask

   // Receiver. It stalls in short random bursts, and once, on request of the
   // stimulus, holds off long enough for the output buffer to fill and the input to
   // stall while requests keep being offered.
   initial begin : receiver
      int hold_len;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) < 2) begin
            hold_len = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int         scenario;
      int         n;
      int         r;
      int         s0;
      int         m0;
      int         h0;
      int         d0;
      int         w0;
      int         offset;
      int         alarm_value [ALARM_COUNT];
      bit         no_alarm;
      bit         enabled;
      logic [7:0] data;
      int         wait_cycles;

      quiet             = 1'b0;
      long_hold_pending = 1'b0;
      issued_count      = 0;
      tick_count        = 0;
      idle_cycles       = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ACT_NONE;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Power-on values first, with the oscillator-stopped flag still
      // set, then unimplemented and disabled-alarm reads.
      issue_request(ACT_READ, ADDR_CONTROL, 8'h00);
      issue_request(ACT_READ, ADDR_SECONDS, 8'h00);
      issue_request(ACT_READ, 4'd0, 8'hFF);
      issue_request(ACT_READ, ADDR_ALARM_LAST, 8'h00);
      // Writing ones to the flag bits must not set them.
      issue_request(ACT_WRITE, ADDR_CONTROL, 8'hFF);
      issue_request(ACT_READ, ADDR_CONTROL, 8'h00);
      // A seconds write drops bit 7 and clears the oscillator-stopped flag.
      issue_request(ACT_WRITE, ADDR_SECONDS, 8'hD9);
      issue_request(ACT_READ, ADDR_SECONDS, 8'h00);
      // 23:59:59 on 28 February 2000, a leap year, so the next day is the 29th.
      issue_request(ACT_WRITE, ADDR_MINUTES, 8'h59);
      issue_request(ACT_WRITE, ADDR_HOURS, 8'h23);
      issue_request(ACT_WRITE, ADDR_DAYS, 8'h28);
      issue_request(ACT_WRITE, ADDR_MONTH, 8'h02);
      issue_request(ACT_WRITE, ADDR_YEAR, 8'h00);
      // Only the seconds alarm is enabled; it matches right after the rollover.
      issue_request(ACT_WRITE, ADDR_ALARM_FIRST, 8'h00);
      issue_request(ACT_WRITE, ADDR_CONTROL, 8'h80);
      issue_request(ACT_TICK, 4'd0, 8'h00);
      issue_request(ACT_READ, ADDR_DAYS, 8'h00);
      issue_request(ACT_READ, ADDR_WEEKDAY, 8'h00);
      // A one in the flag position keeps the alarm flag, a zero clears it.
      issue_request(ACT_WRITE, ADDR_CONTROL, 8'hC0);
      issue_request(ACT_WRITE, ADDR_CONTROL, 8'h80);
      issue_request(ACT_READ, ADDR_CONTROL, 8'h00);
      // The unused action code and writes to unimplemented addresses do nothing.
      issue_request(ACT_NONE, ADDR_CONTROL, 8'hFF);
      issue_request(ACT_WRITE, 4'd2, 8'hFF);
      issue_request(ACT_READ, 4'd2, 8'h00);
      issue_request(ACT_READ, 4'd3, 8'h00);

      // The single long receiver hold-off happens at the start of the random part.
      long_hold_pending = 1'b1;

      while (issued_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         scenario = $urandom_range(0, 99);
         if (scenario < 25) begin
            // Calendar rollover: a time just before midnight on the last days of a
            // month, with odd months, century and wrap years mixed in.
            data = to_bcd($urandom_range(50, 59));
            data[7] = 1'($urandom_range(0, 1));
            issue_request(ACT_WRITE, ADDR_SECONDS, data);
            issue_request(ACT_WRITE, ADDR_MINUTES,
                          ($urandom_range(0, 9) < 8) ? 8'h59 : to_bcd($urandom_range(0, 59)));
            issue_request(ACT_WRITE, ADDR_HOURS,
                          ($urandom_range(0, 9) < 8) ? 8'h23 : to_bcd($urandom_range(0, 23)));
            issue_request(ACT_WRITE, ADDR_WEEKDAY, 8'($urandom_range(0, 7)));
            if ($urandom_range(0, 99) < 85) begin
               data = to_bcd($urandom_range(1, 12));
            end else begin
               data = 8'($urandom_range(0, 31));
            end
            issue_request(ACT_WRITE, ADDR_MONTH, data);
            r = $urandom_range(0, 9);
            case (r)
               0, 1: data = YEAR_LAST;
               2: data = BCD_ZERO;
               3: data = YEAR_CENTURY;
               4: data = 8'($urandom_range(0, 255));
               default: data = to_bcd($urandom_range(0, 99));
            endcase
            issue_request(ACT_WRITE, ADDR_YEAR, data);
            issue_request(ACT_WRITE, ADDR_DAYS, to_bcd($urandom_range(27, 31)));
            n = $urandom_range(1, 12);
            repeat (n) begin
               if ($urandom_range(0, 9) < 7) begin
                  issue_request(ACT_TICK, 4'($urandom_range(0, 15)),
                                8'($urandom_range(0, 255)));
               end else begin
                  issue_request(ACT_READ, 4'($urandom_range(ADDR_SECONDS, ADDR_YEAR)),
                                8'h00);
               end
            end
         end else if (scenario < 50) begin
            // Alarm: a known time, alarm fields derived from it so that matches
            // really happen, sometimes persistently, sometimes never.
            s0 = $urandom_range(0, 35);
            m0 = $urandom_range(0, 59);
            h0 = $urandom_range(0, 23);
            d0 = $urandom_range(1, 28);
            w0 = $urandom_range(0, 6);
            offset = $urandom_range(0, 20);
            issue_request(ACT_WRITE, ADDR_SECONDS, to_bcd(s0));
            issue_request(ACT_WRITE, ADDR_MINUTES, to_bcd(m0));
            issue_request(ACT_WRITE, ADDR_HOURS, to_bcd(h0));
            issue_request(ACT_WRITE, ADDR_DAYS, to_bcd(d0));
            issue_request(ACT_WRITE, ADDR_WEEKDAY, 8'(w0));
            alarm_value = '{s0 + offset, m0, h0, d0, w0};
            no_alarm = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < ALARM_COUNT; k++) begin
               if (k == 0) begin
                  enabled = !no_alarm && ($urandom_range(0, 3) != 0);
               end else begin
                  enabled = !no_alarm && ($urandom_range(0, 1) == 1);
               end
               if (!enabled) begin
                  data = 8'h80 | 8'($urandom_range(0, 127));
               end else if ($urandom_range(0, 9) == 0) begin
                  data = 8'($urandom_range(0, 127));
               end else begin
                  data = to_bcd(alarm_value[k]);
               end
               issue_request(ACT_WRITE, ADDR_ALARM_FIRST + 4'(k), data);
            end
            data = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) < 7) begin
               data[CTL_AIE_BIT] = 1'b1;
            end
            issue_request(ACT_WRITE, ADDR_CONTROL, data);
            n = $urandom_range(5, 30);
            repeat (n) begin
               r = $urandom_range(0, 9);
               if (r < 7) begin
                  issue_request(ACT_TICK, 4'd0, 8'h00);
               end else if (r < 9) begin
                  issue_request(ACT_READ, ADDR_CONTROL, 8'h00);
               end else begin
                  issue_request(ACT_WRITE, ADDR_CONTROL, 8'($urandom_range(0, 255)));
               end
            end
         end else if (scenario < 80) begin
            // Ordinary traffic: reads anywhere, ticks and raw writes.
            n = $urandom_range(1, 8);
            repeat (n) begin
               r = $urandom_range(0, 9);
               if (r < 4) begin
                  issue_request(ACT_TICK, 4'd0, 8'h00);
               end else if (r < 7) begin
                  issue_request(ACT_READ, 4'($urandom_range(0, 15)),
                                8'($urandom_range(0, 255)));
               end else begin
                  issue_request(ACT_WRITE, 4'($urandom_range(0, 15)),
                                8'($urandom_range(0, 255)));
               end
            end
         end else begin
            // Noise: any action code, any address, any byte.
            issue_request(action_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)));
         end
      end

      // The last request was accepted at this edge; lowering valid here is the only
      // assignment to it in this time step.
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_count != 0) begin
         $display("Timed out with %0d responses outstanding", pending_count);
         $display("Some tests failed");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         $display("Issued %0d requests, %0d of them one-second ticks, and compared %0d responses",
                  issued_count, tick_count, response_count);
         $display("Alarm interrupt seen asserted in %0d responses; %0d mismatches found",
                  irq_count, error_count);
         if (error_count == 0 && pending_count == 0) begin
            $display("All tests passed");
         end else begin
            $display("Some tests failed");
         end
         $finish;
      end
   end

endmodule
